### rtl/vt4_pkg.sv
package vt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int PAIR_W    = SH_W + 1;
    localparam int SUM_W     = SH_W + 2;
    localparam int DIM       = 4;
    localparam int IDX_W     = $clog2(DIM * DIM);

    // input word: element_index, element_value, vec_x..vec_w, zero pad to bytes
    localparam int IN_BITS   = IDX_W + WORD_W + DIM * WORD_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = DIM * WORD_W;

    localparam logic [WORD_W-1:0] FIX_ONE = WORD_W'(1) << FRAC_BITS;

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } t_op;

    typedef logic [WORD_W-1:0]          t_word;
    typedef logic [DIM-1:0][WORD_W-1:0] t_vec4;

    typedef struct packed {
        logic  sat;
        t_vec4 vals;
    } t_result;

endpackage

### rtl/vt4_row.sv
module vt4_row (
    input  logic           i_clk,
    input  logic           i_en,
    input  vt4_pkg::t_vec4 i_row,
    input  vt4_pkg::t_vec4 i_vec,
    output vt4_pkg::t_word o_value,
    output logic           o_sat
);
    import vt4_pkg::*;

    logic signed [PROD_W-1:0] r_prod [DIM];
    logic signed [PROD_W-1:0] n_prod [DIM];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [PAIR_W-1:0] n_pair [2];
    logic signed [SH_W-1:0]   w_sh   [DIM];
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-WORD_W:0]    w_upper;
    logic                     w_hi;
    logic                     w_lo;
    t_word                    r_value;
    t_word                    n_value;
    logic                     r_sat;
    logic                     n_sat;

    // stage 1: element-by-component products
    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            n_prod[c] = PROD_W'($signed(i_row[c])) * PROD_W'($signed(i_vec[c]));
        end
    end

    // stage 2: floor shift and pairwise sums
    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            w_sh[c] = SH_W'(r_prod[c] >>> FRAC_BITS);
        end
        n_pair[0] = PAIR_W'(w_sh[0]) + PAIR_W'(w_sh[1]);
        n_pair[1] = PAIR_W'(w_sh[2]) + PAIR_W'(w_sh[3]);
    end

    // stage 3: final add and clip; out of range when the top bits disagree
    always_comb begin
        w_sum   = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
        w_upper = w_sum[SUM_W-1:WORD_W-1];
        w_hi    = !w_sum[SUM_W-1] && (|w_upper);
        w_lo    = w_sum[SUM_W-1] && !(&w_upper);
        n_sat   = w_hi || w_lo;
        if (w_hi) begin
            n_value = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (w_lo) begin
            n_value = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            n_value = w_sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_pair  <= n_pair;
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

### rtl/vertex_transform_4x4.sv
// 4x4 matrix times vector engine, signed Q16.16.
// Input stream (s_axis): tuser selects the word kind. A load word writes one
// element of the stored matrix at row*4+col and produces no output. A
// transform word carries a vector and produces one output word holding the
// stored matrix times that vector, each component saturated to 32 bits, with
// tuser flagging that at least one component was clipped.
// Pipeline: a transform accepted on s_axis goes through products, shift and
// pair sums, final add and clip, then the output register, to m_axis.
// Throughput: one word per cycle while s_axis_tready is high, loads and
// transforms mixed freely; a load takes effect for the next transform word.
// Reset: the matrix returns to identity and the pipeline empties.
// Stall: the pipeline keeps moving until its last word has to park in the
// skid register behind the output register; then s_axis_tready drops until
// the receiver takes the output. Nothing is dropped or repeated.
module vertex_transform_4x4 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // element_index, element_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  logic [vt4_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [vt4_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic [0:0]                     m_axis_tuser
);
    import vt4_pkg::*;

    localparam int VAL_LO = IDX_W;
    localparam int VEC_LO = IDX_W + WORD_W;

    t_word          r_mat [DIM*DIM];
    logic           w_en;
    logic           w_fire;
    t_op            w_op;
    logic [IDX_W-1:0] w_idx;
    t_word          w_elem;
    t_vec4          w_vec;
    t_vec4          w_rows [DIM];
    t_result        w_res;
    logic [DIM-1:0] w_sat;
    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    logic           r_out_v;
    logic           r_skid_v;
    t_result        r_out;
    t_result        r_skid;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;
    assign w_fire        = s_axis_tvalid && w_en;
    assign w_op          = t_op'(s_axis_tuser[0]);
    assign w_idx         = s_axis_tdata[IDX_W-1:0];
    assign w_elem        = s_axis_tdata[VAL_LO +: WORD_W];

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            w_vec[c] = s_axis_tdata[VEC_LO + c*WORD_W +: WORD_W];
        end
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                w_rows[r][c] = r_mat[r*DIM + c];
            end
        end
    end

    // matrix store; a transform's products are taken before a later load lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM*DIM; i++) begin
                r_mat[i] <= (i % (DIM + 1) == 0) ? FIX_ONE : '0;
            end
        end else if (w_fire && w_op == OP_LOAD) begin
            r_mat[w_idx] <= w_elem;
        end
    end

    for (genvar g = 0; g < DIM; g++) begin : g_row
        vt4_row u_row (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_row   (w_rows[g]),
            .i_vec   (w_vec),
            .o_value (w_res.vals[g]),
            .o_sat   (w_sat[g])
        );
    end

    assign w_res.sat = |w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v1 <= w_fire && w_op == OP_TRANSFORM;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
            if (r_skid_v) begin
                if (m_axis_tready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_v3) begin
                if (!r_out_v || m_axis_tready) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (r_v3) begin
            if (!r_out_v || m_axis_tready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign m_axis_tvalid   = r_out_v;
    assign m_axis_tdata    = r_out.vals;
    assign m_axis_tuser[0] = r_out.sat;

endmodule

### test/vt4_check.sv
`timescale 1ns / 100ps

// Watches both stream channels of vertex_transform_4x4, keeps its own copy of
// the stored matrix and predicts every output word of a transform.
module vt4_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [vt4_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [vt4_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [0:0]                     i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import vt4_pkg::*;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic signed [WORD_W-1:0] matrix [DIM*DIM];
    t_result                  expected_vertices [$];

    initial o_fail_count = 0;

    task automatic report_mismatch(input string field, input t_word got, input t_word want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        o_fail_count++;
    endtask

    // rows of the stored matrix dotted with v, products floored after the shift
    function automatic t_result transform_vertex(input t_vec4 v);
        t_result r;
        longint  sum;
        longint  prod;
        r.sat = 1'b0;
        for (int row = 0; row < DIM; row++) begin
            sum = 0;
            for (int col = 0; col < DIM; col++) begin
                prod = longint'(matrix[row*DIM+col]) * longint'($signed(v[col]));
                sum += prod >>> FRAC_BITS;
            end
            if (sum > SUM_MAX) begin
                sum = SUM_MAX;
                r.sat = 1'b1;
            end else if (sum < SUM_MIN) begin
                sum = SUM_MIN;
                r.sat = 1'b1;
            end
            r.vals[row] = sum[WORD_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DIM*DIM; i++)
                matrix[i] = (i % (DIM + 1) == 0) ? FIX_ONE : '0;
            expected_vertices.delete();
            o_pending = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser[0], i_m_tdata};
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected word", got.vals[0], '0);
                end else begin
                    want = expected_vertices.pop_front();
                    if (got.vals[0] !== want.vals[0])
                        report_mismatch("out_x", got.vals[0], want.vals[0]);
                    if (got.vals[1] !== want.vals[1])
                        report_mismatch("out_y", got.vals[1], want.vals[1]);
                    if (got.vals[2] !== want.vals[2])
                        report_mismatch("out_z", got.vals[2], want.vals[2]);
                    if (got.vals[3] !== want.vals[3])
                        report_mismatch("out_w", got.vals[3], want.vals[3]);
                    if (got.sat !== want.sat)
                        report_mismatch("saturated", t_word'(got.sat), t_word'(want.sat));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_op'(i_s_tuser[0]) == OP_LOAD)
                    matrix[i_s_tdata[IDX_W-1:0]] = i_s_tdata[IDX_W +: WORD_W];
                else
                    expected_vertices.push_back(
                        transform_vertex(i_s_tdata[IDX_W+WORD_W +: DIM*WORD_W]));
            end
            o_pending = expected_vertices.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vt4_pkg::*;

    localparam t_word FIX_MAX = 32'h7FFF_FFFF;
    localparam t_word FIX_MIN = 32'h8000_0000;
    localparam t_word FIX_NEG = 32'hFFFF_FFFF;
    localparam int    HOLD_CYCLES = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int fail_count;
    int pending;
    bit idle_on;
    bit stall_request;

    vertex_transform_4x4 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    vt4_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** vertex_transform_4x4: FAILED **");
        $finish;
    end

    function automatic t_vec4 vec4(input t_word x, input t_word y, input t_word z,
                                   input t_word w);
        return {w, z, y, x};
    endfunction

    // mix of full-range, small, integer, fractional and extreme Q16.16 values
    function automatic t_word rand_fix();
        t_word v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = t_word'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = FIX_MAX;
                    1:       v = FIX_MIN;
                    2:       v = '0;
                    default: v = FIX_NEG;
                endcase
            end
            8: begin
                v = t_word'(int'($urandom_range(1, 100)) << FRAC_BITS);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: begin
                v = $urandom_range(0, 65535);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_vec4 rand_vec();
        return vec4(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    endfunction

    // entered and left at a falling edge; tvalid stays high on return
    task automatic offer_word(input t_op op, input logic [IDX_W-1:0] idx, input t_word val,
                              input t_vec4 v);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, v, val, idx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_element(input logic [IDX_W-1:0] idx, input t_word val);
        offer_word(OP_LOAD, idx, val, rand_vec());
    endtask

    task automatic transform(input t_vec4 v);
        offer_word(OP_TRANSFORM, IDX_W'($urandom), $urandom, v);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        t_op op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_TRANSFORM;
            offer_word(op, IDX_W'($urandom), rand_fix(), rand_vec());
        end
    endtask

    // receiver: random ready-low gaps, plus one long hold-off on request
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_on       = 1'b1;
        stall_request = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity passes extremes straight through
        transform(vec4(FIX_MAX, FIX_MIN, '0, FIX_NEG));
        transform(vec4(FIX_ONE, -FIX_ONE, 32'h1, FIX_MAX));
        // positive clip on row 0
        load_element(4'd0, FIX_MAX);
        load_element(4'd1, FIX_MAX);
        transform(vec4(FIX_MAX, FIX_MAX, '0, '0));
        // negative clip on row 0, positive on row 1
        load_element(4'd5, FIX_MIN);
        transform(vec4(FIX_MIN, FIX_MIN, '0, '0));
        // tiny negative product floors to -1, tiny positive to 0
        load_element(4'd15, FIX_NEG);
        transform(vec4('0, '0, '0, 32'h1));
        transform(vec4('0, '0, '0, FIX_NEG));
        load_element(4'd10, '0);
        transform(rand_vec());
        // back to identity
        load_element(4'd0, FIX_ONE);
        load_element(4'd1, '0);
        load_element(4'd5, FIX_ONE);
        load_element(4'd10, FIX_ONE);
        load_element(4'd15, FIX_ONE);
        transform(vec4($urandom, $urandom, $urandom, $urandom));
        transform(rand_vec());
        wait_drained();

        run_random(550);
        wait_drained();

        stall_request = 1'b1;
        run_random(550);
        wait_drained();

        idle_on = 1'b0;
        run_random(580);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** vertex_transform_4x4: PASSED **");
        else
            $display("** vertex_transform_4x4: FAILED **");
        $finish;
    end

endmodule

### vertex_transform_4x4.f
rtl/vt4_pkg.sv
rtl/vt4_row.sv
rtl/vertex_transform_4x4.sv
test/vt4_check.sv
test/tb_top.sv
